[design/cv_pkg.sv]
`default_nettype none

package cv_pkg;

    localparam int unsigned CharW    = 8;
    localparam int unsigned CountW   = 4;
    localparam int unsigned SuffixW  = 2;

    localparam logic [CharW-1:0] ChQ     = 8'h51;
    localparam logic [CharW-1:0] ChL     = 8'h4C;
    localparam logic [CharW-1:0] ChB     = 8'h42;
    localparam logic [CharW-1:0] ChC     = 8'h43;
    localparam logic [CharW-1:0] ChDash  = 8'h2D;
    localparam logic [CharW-1:0] ChZero  = 8'h30;
    localparam logic [CharW-1:0] ChSpace = 8'h20;
    localparam logic [CharW-1:0] CaseBit = 8'h20;

    localparam logic [CountW-1:0]  CountMax  = 4'd15;
    localparam logic [CountW-1:0]  PrefixMin = 4'd4;
    localparam logic [CountW-1:0]  PrefixMax = 4'd7;
    localparam logic [SuffixW-1:0] SuffixMax = 2'd3;
    localparam logic [SuffixW-1:0] SsidMax   = 2'd2;

    typedef struct packed {
        logic [CharW-1:0] code;
        logic             space;
        logic             upper;
        logic             digit;
        logic             dash;
        logic             q;
    } char_class_t;

    typedef struct packed {
        logic is_q_code;
        logic is_beacon;
        logic is_broadcast;
        logic is_local;
        logic valid_res;
    } verdict_t;

    function automatic logic is_upper_f(input logic [CharW-1:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

endpackage

`default_nettype wire

[design/cv_classify.sv]
`default_nettype none

module cv_classify (
    input  wire logic [cv_pkg::CharW-1:0] char_code,
    output cv_pkg::char_class_t           cls
);
    import cv_pkg::*;

    logic [CharW-1:0] up;

    always_comb begin
        up = char_code;
        if ((char_code >= 8'h61) && (char_code <= 8'h7A)) begin
            up = char_code - CaseBit;
        end
        cls.code  = up;
        cls.space = (up == ChSpace) || ((up >= 8'h09) && (up <= 8'h0D));
        cls.upper = is_upper_f(up);
        cls.digit = (up >= 8'h30) && (up <= 8'h39);
        cls.dash  = (up == ChDash);
        cls.q     = (up == ChQ);
    end

endmodule

`default_nettype wire

[design/cv_track.sv]
`default_nettype none

module cv_track (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                advance,
    input  wire logic                last_char,
    input  wire cv_pkg::char_class_t cls,
    output cv_pkg::verdict_t         verdict
);
    import cv_pkg::*;

    logic               skipping_reg, skipping_next;
    logic [CountW-1:0]  content_reg, content_next;
    logic [CharW-1:0]   first_reg, first_next;
    logic [CharW-1:0]   second_reg, second_next;
    logic               dash_reg, dash_next;
    logic [CountW-1:0]  prefix_reg, prefix_next;
    logic [SuffixW-1:0] suffix_reg, suffix_next;
    logic               bad_reg, bad_next;
    logic               gap_reg, gap_next;
    logic               qf;

    // per-character state update
    always_comb begin
        skipping_next = skipping_reg;
        content_next  = content_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        dash_next     = dash_reg;
        prefix_next   = prefix_reg;
        suffix_next   = suffix_reg;
        bad_next      = bad_reg;
        gap_next      = gap_reg;
        if (cls.space) begin
            if (!skipping_reg) begin
                gap_next = 1'b1;
            end
        end else begin
            skipping_next = 1'b0;
            if (gap_reg) begin
                content_next = CountMax;
                bad_next     = 1'b1;
            end else begin
                if (content_reg == '0) begin
                    first_next = cls.code;
                    if (!cls.upper || cls.q) begin
                        bad_next = 1'b1;
                    end
                    if (prefix_reg != CountMax) begin
                        prefix_next = prefix_reg + 1'b1;
                    end
                end else begin
                    if (content_reg == 4'd1) begin
                        second_next = cls.code;
                    end
                    if (!dash_reg) begin
                        if (cls.dash) begin
                            dash_next = 1'b1;
                        end else begin
                            if (!cls.upper && !cls.digit) begin
                                bad_next = 1'b1;
                            end
                            if (prefix_reg != CountMax) begin
                                prefix_next = prefix_reg + 1'b1;
                            end
                        end
                    end else begin
                        if (!cls.digit || ((suffix_reg == '0) && (cls.code == ChZero))) begin
                            bad_next = 1'b1;
                        end
                        if (suffix_reg != SuffixMax) begin
                            suffix_next = suffix_reg + 1'b1;
                        end
                    end
                end
                if (content_reg != CountMax) begin
                    content_next = content_reg + 1'b1;
                end
            end
        end
    end

    // verdict from the state after this character
    always_comb begin
        if (content_next < 4'd2) begin
            verdict.valid_res = 1'b0;
        end else if (content_next == 4'd2) begin
            verdict.valid_res = (first_next == ChQ) && is_upper_f(second_next);
        end else begin
            verdict.valid_res = !bad_next
                && (prefix_next >= PrefixMin) && (prefix_next <= PrefixMax)
                && (!dash_next || ((suffix_next != '0) && (suffix_next <= SsidMax)));
        end
        qf = verdict.valid_res && (content_next == 4'd2) && (first_next == ChQ);
        verdict.is_local     = qf && (second_next == ChL);
        verdict.is_broadcast = qf && ((second_next == ChB) || (second_next == ChC));
        verdict.is_beacon    = qf && (second_next == ChB);
        verdict.is_q_code    = verdict.valid_res && (first_next == ChQ);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && last_char)) begin
            skipping_reg <= 1'b1;
            content_reg  <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
            dash_reg     <= 1'b0;
            prefix_reg   <= '0;
            suffix_reg   <= '0;
            bad_reg      <= 1'b0;
            gap_reg      <= 1'b0;
        end else if (advance) begin
            skipping_reg <= skipping_next;
            content_reg  <= content_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            dash_reg     <= dash_next;
            prefix_reg   <= prefix_next;
            suffix_reg   <= suffix_next;
            bad_reg      <= bad_next;
            gap_reg      <= gap_next;
        end
    end

endmodule

`default_nettype wire

[design/callsign_validator_top.sv]
`default_nettype none

// Callsign validator. Feed the callsign one byte per item on the s_ channel,
// with s_tlast on the final byte; one verdict item appears on the m_ channel
// for each s_tlast, and nothing for other bytes. The block takes one byte
// per cycle unless a stall holds it: each byte is held in an input register,
// then folded into the running state, and the verdict is held in an output
// register. A full output register stalls only a byte carrying s_tlast;
// other bytes keep flowing. State clears itself after each verdict.
module callsign_validator_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_code
    input  wire logic       s_tlast,   // last_char
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] valid_res, [1] is_local, [2] is_broadcast,
                                       // [3] is_beacon, [4] is_q_code, [7:5] zero
);
    import cv_pkg::*;

    logic             in_valid_reg;
    logic [CharW-1:0] char_reg;
    logic             last_reg;
    logic             out_valid_reg;
    verdict_t         out_reg;
    logic             advance;
    char_class_t      cls;
    verdict_t         verdict;

    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    cv_classify u_classify (
        .char_code (char_reg),
        .cls       (cls)
    );

    cv_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .last_char (last_reg),
        .cls       (cls),
        .verdict   (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && last_reg) begin
            out_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

endmodule

`default_nettype wire

[dv/callsign_validator_top_tb.sv]
`timescale 1ns / 1ps

module callsign_validator_top_tb;
    import cv_pkg::*;

    localparam int StallLimit = 2000;
    localparam int PrintCap   = 100;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    callsign_validator_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Callsign tracker state
    logic               cs_skip_lead;
    logic [CountW-1:0]  cs_content;
    logic [CharW-1:0]   cs_first;
    logic [CharW-1:0]   cs_second;
    logic               cs_dash;
    logic [CountW-1:0]  cs_prefix;
    logic [SuffixW-1:0] cs_suffix;
    logic               cs_bad;
    logic               cs_gap;

    verdict_t   verdict_q[$];
    verdict_t   want_v;
    verdict_t   seen_v;
    logic [7:0] line_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_errors      = 0;
    int n_chars       = 0;
    int n_verdicts    = 0;
    int n_valid       = 0;
    int n_q_codes     = 0;
    int n_local       = 0;
    int n_broadcast   = 0;
    int n_reserved    = 0;
    int stall_cycles  = 0;

    function automatic logic cap_letter(input logic [7:0] c);
        return c >= 8'h41 && c <= 8'h5A;
    endfunction

    function automatic logic num_char(input logic [7:0] c);
        return c >= ChZero && c <= ChZero + 8'd9;
    endfunction

    task automatic clear_callsign();
        cs_skip_lead = 1'b1;
        cs_content   = '0;
        cs_first     = '0;
        cs_second    = '0;
        cs_dash      = 1'b0;
        cs_prefix    = '0;
        cs_suffix    = '0;
        cs_bad       = 1'b0;
        cs_gap       = 1'b0;
    endtask

    task automatic fold_char(input logic [7:0] raw, input logic lst);
        logic [7:0] c;
        logic       ok;
        logic       two_char;
        verdict_t   v;
        c = (raw >= 8'h61 && raw <= 8'h7A) ? (raw ^ CaseBit) : raw;
        if (c == ChSpace || (c >= 8'd9 && c <= 8'd13)) begin
            if (!cs_skip_lead) cs_gap = 1'b1;
        end else begin
            cs_skip_lead = 1'b0;
            if (cs_gap) begin
                cs_content = CountMax;
                cs_bad     = 1'b1;
            end else begin
                if (cs_content == 0) begin
                    cs_first = c;
                    if (!cap_letter(c) || c == ChQ) cs_bad = 1'b1;
                    if (cs_prefix != CountMax) cs_prefix++;
                end else begin
                    if (cs_content == 1) cs_second = c;
                    if (!cs_dash) begin
                        if (c == ChDash) begin
                            cs_dash = 1'b1;
                        end else begin
                            if (!cap_letter(c) && !num_char(c)) cs_bad = 1'b1;
                            if (cs_prefix != CountMax) cs_prefix++;
                        end
                    end else begin
                        if (!num_char(c)) cs_bad = 1'b1;
                        if (cs_suffix == 0 && c == ChZero) cs_bad = 1'b1;
                        if (cs_suffix != SuffixMax) cs_suffix++;
                    end
                end
                if (cs_content != CountMax) cs_content++;
            end
        end
        if (lst) begin
            if (cs_content < 2) begin
                ok = 1'b0;
            end else if (cs_content == 2) begin
                ok = cs_first == ChQ && cap_letter(cs_second);
            end else begin
                ok = !cs_bad && cs_prefix >= PrefixMin && cs_prefix <= PrefixMax
                     && (!cs_dash || (cs_suffix >= 2'd1 && cs_suffix <= SsidMax));
            end
            two_char       = ok && cs_content == 2;
            v              = '0;
            v.valid_res    = ok;
            v.is_local     = two_char && cs_first == ChQ && cs_second == ChL;
            v.is_broadcast = two_char && cs_first == ChQ
                             && (cs_second == ChB || cs_second == ChC);
            v.is_beacon    = two_char && cs_first == ChQ && cs_second == ChB;
            v.is_q_code    = ok && cs_first == ChQ;
            verdict_q.push_back(v);
            clear_callsign();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] seen);
        n_errors++;
        if (n_errors <= PrintCap)
            $display("ERROR at %0t ns: %s expected %0h got %0h", $time, what, want, seen);
    endtask

    task automatic send_char(input logic [7:0] c, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        n_chars++;
        fold_char(c, lst);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++)
            send_char(line_q[i], i == line_q.size() - 1);
        line_q.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
        send_line();
    endtask

    // valid drops here; caller must not have driven it in this step
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        return $urandom_range(1) ? (c | CaseBit) : c;
    endfunction

    function automatic logic [7:0] pick_letter(input logic allow_q);
        logic [7:0] c;
        do c = 8'h41 + 8'($urandom_range(25)); while (!allow_q && c == ChQ);
        return mix_case(c);
    endfunction

    function automatic logic [7:0] pick_alnum();
        if ($urandom_range(9) < 3) return ChZero + 8'($urandom_range(9));
        return pick_letter(1'b1);
    endfunction

    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? ChSpace : 8'd9 + 8'(r);
    endfunction

    task automatic build_long_prefix(input int n_tail);
        line_q.push_back(pick_letter(1'b0));
        repeat (n_tail) line_q.push_back(pick_alnum());
    endtask

    task automatic build_callsign();
        logic [7:0] q2;
        line_q.delete();
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0)
            line_q.push_back(pick_space());
        if ($urandom_range(3) == 0) begin
            line_q.push_back(mix_case(ChQ));
            case ($urandom_range(3))
                0:       q2 = mix_case(ChL);
                1:       q2 = mix_case(ChB);
                2:       q2 = mix_case(ChC);
                default: q2 = pick_letter(1'b1);
            endcase
            line_q.push_back(q2);
        end else begin
            build_long_prefix($urandom_range(3, 6));
            if ($urandom_range(1)) begin
                line_q.push_back(ChDash);
                line_q.push_back(ChZero + 8'($urandom_range(1, 9)));
                if ($urandom_range(1)) line_q.push_back(ChZero + 8'($urandom_range(9)));
            end
        end
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0)
            line_q.push_back(pick_space());
    endtask

    task automatic test_directed();
        send_text("\tql");          // leading tab, lower case, local
        send_text("qB\015");        // trailing CR, reserved beacon
        send_text(" ");             // empty
        send_text("A");             // single character
        send_text("-A");            // dash first
        send_text("Q-");            // dash as second of two
        send_text("K1AB-9");        // long form with SSID
        send_text("QL Q");          // inner whitespace
        send_text("\377Z");         // high byte
        wait_drained();
    endtask

    task automatic test_wellformed(input int count);
        repeat (count) begin
            build_callsign();
            send_line();
        end
    endtask

    task automatic test_malformed(input int count);
        int k;
        repeat (count) begin
            build_callsign();
            case ($urandom_range(7))
                0: line_q.insert($urandom_range(1, line_q.size() - 1), pick_space());
                1: line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
                2: line_q.insert($urandom_range(line_q.size() - 1), ChDash);
                3: begin
                    line_q.delete();
                    build_long_prefix($urandom_range(3, 6));
                    line_q.push_back(ChDash);
                    line_q.push_back(ChZero);
                    if ($urandom_range(1)) line_q.push_back(pick_alnum());
                end
                4: begin
                    line_q.delete();
                    build_long_prefix($urandom_range(3, 6));
                    line_q.push_back(ChDash);
                    k = $urandom_range(3) == 0 ? 0 : $urandom_range(3, 4);
                    repeat (k) line_q.push_back(ChZero + 8'($urandom_range(1, 9)));
                end
                5: begin
                    line_q.delete();
                    build_long_prefix($urandom_range(1) ? $urandom_range(2)
                                                        : $urandom_range(7, 18));
                end
                6: begin
                    line_q.delete();
                    line_q.push_back(mix_case(ChQ));
                    if ($urandom_range(1)) line_q.push_back(ChZero + 8'($urandom_range(9)));
                    else repeat ($urandom_range(2, 4)) line_q.push_back(pick_letter(1'b1));
                end
                default: begin
                    line_q.delete();
                    repeat ($urandom_range(1, 3)) line_q.push_back(pick_space());
                end
            endcase
            send_line();
        end
    endtask

    task automatic test_noise(input int count);
        repeat (count) send_char(8'($urandom_range(255)), $urandom_range(7) == 0);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        test_wellformed(36);
        test_malformed(30);
        test_noise(120);
        send_text("QC");
        wait_drained();
    endtask

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("verdict with none pending", 8'h00, m_tdata);
            end else begin
                want_v = verdict_q.pop_front();
                seen_v = m_tdata[4:0];
                if (seen_v.valid_res !== want_v.valid_res)
                    report_mismatch("valid_res", 8'(want_v.valid_res),
                                    8'(seen_v.valid_res));
                if (seen_v.is_local !== want_v.is_local)
                    report_mismatch("is_local", 8'(want_v.is_local),
                                    8'(seen_v.is_local));
                if (seen_v.is_broadcast !== want_v.is_broadcast)
                    report_mismatch("is_broadcast", 8'(want_v.is_broadcast),
                                    8'(seen_v.is_broadcast));
                if (seen_v.is_beacon !== want_v.is_beacon)
                    report_mismatch("is_beacon", 8'(want_v.is_beacon),
                                    8'(seen_v.is_beacon));
                if (seen_v.is_q_code !== want_v.is_q_code)
                    report_mismatch("is_q_code", 8'(want_v.is_q_code),
                                    8'(seen_v.is_q_code));
                if (m_tdata[7:5] !== 3'b000)
                    report_mismatch("pad bits", 8'h00, 8'(m_tdata[7:5]));
                n_verdicts++;
                n_valid     += want_v.valid_res;
                n_q_codes   += want_v.is_q_code;
                n_local     += want_v.is_local;
                n_broadcast += want_v.is_broadcast;
                n_reserved  += want_v.is_beacon;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("timeout: no item moved for %0d cycles", StallLimit);
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        clear_callsign();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 29;
        recv_idle_pct = 71;
        test_directed();
        run_phase(29, 71);
        run_phase(71, 29);
        run_phase(0, 0);
        $display("covered %0d chars, %0d verdicts: %0d valid, %0d Q codes",
                 n_chars, n_verdicts, n_valid, n_q_codes);
        $display("flags seen: %0d local, %0d broadcast, %0d reserved; %0d mismatches",
                 n_local, n_broadcast, n_reserved, n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
